// ----- design/stq_pkg.sv -----
// Package for the sorted timer queue: opcodes, result kinds, state encoding.
package stq_pkg;

	localparam int SLOTS_DEF = 16;
	localparam int EXP_W = 64;
	localparam int DELTA_W = 32;
	localparam logic [31:0] MIN_DELTA_RST = 32'd1000;
	localparam logic [31:0] MAX_DELTA_RST = 32'hFFFF_FFFF;

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_CANCEL = 2'd1;
	localparam logic [1:0] OP_DRIVE = 2'd2;

	localparam logic [1:0] KIND_FIRED = 2'd0;
	localparam logic [1:0] KIND_PROG = 2'd1;
	localparam logic [1:0] KIND_NOPROG = 2'd2;

	localparam logic REG_MIN = 1'b0;
	localparam logic REG_MAX = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RM_RD,
		ST_RM_CHK,
		ST_INS_RD,
		ST_INS_EXP,
		ST_INS_CHK,
		ST_INS_WR,
		ST_DRV_RD,
		ST_DRV_EXP,
		ST_DRV_CHK,
		ST_CMP_RD,
		ST_CMP_WR,
		ST_PRG_RD,
		ST_PRG_EXP,
		ST_PRG_CHK
	} state_t;

endpackage

// ----- design/stq_ram.sv -----
// Generic simple dual-port synchronous RAM (one write port, one read port) with registered read.
module stq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ----- design/sorted_timer_queue.sv -----
// Sorted timer queue top level: config registers, sequencer, queue and expiry memories.
// Each transaction walks the ordered queue held in the order memory, one entry at a time.
// Removing a slot (cancel, or add of an active slot) reads and checks each queued entry in turn
// and moves the entries behind it up. An add then inserts from the tail, moving each later entry
// back one place until it stops behind an entry or at the head, then writes the slot. The program
// scan reads entries up to the first one still in the future. A drive reports each fired slot,
// stops at the first future entry, closes the gap by moving the remaining entries up, then runs
// the program scan. Each result is registered and on the ports in the cycle after it is computed,
// and busy falls in the cycle that shows the final result (last high). Results cannot be stalled.
// No two memory accesses to one entry overlap, so there is no forwarding.
module sorted_timer_queue
	import stq_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	input  logic         start,
	output logic         busy,
	input  logic [1:0]   op,
	input  logic [3:0]   slot,
	input  logic signed [EXP_W-1:0] expires,
	input  logic signed [EXP_W-1:0] now,
	output logic         strobe,
	output logic [1:0]   kind,
	output logic [3:0]   fired_slot,
	output logic [DELTA_W-1:0] delta,
	output logic         last
);
	localparam int AW = $clog2(SLOTS);
	localparam int LW = $clog2(SLOTS + 1);

	logic [31:0] min_q, max_q;
	state_t state_q, state_d;
	logic [SLOTS-1:0] active_q;
	logic [LW-1:0] len_q;
	logic [LW-1:0] idx_q;
	logic [LW-1:0] cnt_q; // slots fired by a drive
	logic found_q;
	logic [1:0] op_q;
	logic [AW-1:0] slot_q;
	logic [EXP_W-1:0] exp_q, now_q;
	logic [AW-1:0] cur_q; // slot read from queue memory
	logic strobe_q, last_q;
	logic [1:0] kind_q;
	logic [3:0] fired_q;
	logic [DELTA_W-1:0] delta_q;

	// memory ports
	logic q_we, e_we;
	logic [AW-1:0] q_wa, q_ra, e_wa, e_ra;
	logic [AW-1:0] q_wd, q_rd;
	logic [EXP_W-1:0] e_wd, e_rd;

	logic cfg_wr;
	logic accept;
	logic [7:0] slot_w, cur_w;
	logic [AW-1:0] slot_ix;
	logic slot_ok;
	logic [EXP_W-1:0] sgn;
	logic e_gt_exp, e_gt_now;
	logic [EXP_W-1:0] diff;
	logic lt_min, gt_max;
	logic [DELTA_W-1:0] dclamp;
	logic [LW-1:0] idx_inc, idx_dec;
	logic [LW:0] cmp_src;
	logic idx_end, cmp_done;
	logic emit_fire, emit_prog, emit_none;

	stq_ram #(.WIDTH(AW), .DEPTH(SLOTS)) u_order (
		.clk(clk), .we(q_we), .waddr(q_wa), .wdata(q_wd), .raddr(q_ra), .rdata(q_rd));
	stq_ram #(.WIDTH(EXP_W), .DEPTH(SLOTS)) u_expiry (
		.clk(clk), .we(e_we), .waddr(e_wa), .wdata(e_wd), .raddr(e_ra), .rdata(e_rd));

	// APB
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	always_comb begin
		case (paddr[2])
			REG_MIN: prdata = min_q;
			REG_MAX: prdata = max_q;
			default: prdata = min_q;
		endcase
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= MIN_DELTA_RST;
			max_q <= MAX_DELTA_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_MIN) min_q <= pwdata;
			else max_q <= pwdata;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign accept = start && !busy;

	assign slot_w = {4'd0, slot};
	assign slot_ix = slot_w[AW-1:0];
	assign slot_ok = ({28'd0, slot} < 32'(SLOTS));
	assign cur_w = 8'(cur_q);

	// signed compares via sign flip
	assign sgn = {1'b1, {(EXP_W-1){1'b0}}};
	assign e_gt_exp = (e_rd ^ sgn) > (exp_q ^ sgn);
	assign e_gt_now = (e_rd ^ sgn) > (now_q ^ sgn);

	// max first, then min: with min above max the result is always max
	assign diff = e_rd - now_q;
	assign lt_min = diff < {32'd0, min_q};
	assign gt_max = diff > {32'd0, max_q};
	always_comb begin
		if (min_q > max_q || gt_max) dclamp = max_q;
		else if (lt_min) dclamp = min_q;
		else dclamp = diff[DELTA_W-1:0];
	end

	assign idx_inc = idx_q + LW'(1);
	assign idx_dec = idx_q - LW'(1);
	assign cmp_src = {1'b0, idx_q} + {1'b0, cnt_q};
	assign idx_end = (idx_q >= len_q);
	assign cmp_done = (cnt_q == '0) || (cmp_src >= {1'b0, len_q});

	always_comb begin
		state_d = state_q;
		q_we = 1'b0;
		q_wa = AW'(idx_q);
		q_wd = cur_q;
		q_ra = AW'(idx_q);
		e_we = 1'b0;
		e_wa = slot_q;
		e_wd = exp_q;
		e_ra = cur_q;
		emit_fire = 1'b0;
		emit_prog = 1'b0;
		emit_none = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (op)
						OP_ADD: begin
							if (slot_ok)
								state_d = active_q[slot_ix] ? ST_RM_RD : ST_INS_RD;
						end
						OP_CANCEL: begin
							if (slot_ok && active_q[slot_ix])
								state_d = ST_RM_RD;
						end
						OP_DRIVE: state_d = ST_DRV_RD;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_RM_RD: begin
				if (idx_end) state_d = (op_q == OP_ADD) ? ST_INS_RD : ST_PRG_RD;
				else state_d = ST_RM_CHK;
			end
			ST_RM_CHK: begin
				// entries behind the removed slot move up by one
				q_we = found_q;
				q_wa = AW'(idx_dec);
				q_wd = q_rd;
				state_d = ST_RM_RD;
			end
			ST_INS_RD: begin
				q_ra = AW'(idx_dec);
				state_d = (idx_q == '0) ? ST_INS_WR : ST_INS_EXP;
			end
			ST_INS_EXP: begin
				e_ra = q_rd;
				state_d = ST_INS_CHK;
			end
			ST_INS_CHK: begin
				// later expiry moves back one place; ties stay ahead
				if (e_gt_exp) begin
					q_we = 1'b1;
					state_d = ST_INS_RD;
				end else begin
					state_d = ST_INS_WR;
				end
			end
			ST_INS_WR: begin
				q_we = 1'b1;
				q_wd = slot_q;
				e_we = 1'b1;
				state_d = ST_PRG_RD;
			end
			ST_DRV_RD: state_d = idx_end ? ST_CMP_RD : ST_DRV_EXP;
			ST_DRV_EXP: begin
				e_ra = q_rd;
				state_d = ST_DRV_CHK;
			end
			ST_DRV_CHK: begin
				if (!e_gt_now) begin
					emit_fire = active_q[cur_q];
					state_d = ST_DRV_RD;
				end else begin
					state_d = ST_CMP_RD;
				end
			end
			ST_CMP_RD: begin
				q_ra = AW'(cmp_src);
				state_d = cmp_done ? ST_PRG_RD : ST_CMP_WR;
			end
			ST_CMP_WR: begin
				q_we = 1'b1;
				q_wd = q_rd;
				state_d = ST_CMP_RD;
			end
			ST_PRG_RD: begin
				if (idx_end) begin
					emit_none = 1'b1;
					state_d = ST_IDLE;
				end else begin
					state_d = ST_PRG_EXP;
				end
			end
			ST_PRG_EXP: begin
				e_ra = q_rd;
				state_d = ST_PRG_CHK;
			end
			ST_PRG_CHK: begin
				if (active_q[cur_q] && e_gt_now) begin
					emit_prog = 1'b1;
					state_d = ST_IDLE;
				end else begin
					state_d = ST_PRG_RD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	assign strobe = strobe_q;
	assign kind = kind_q;
	assign fired_slot = fired_q;
	assign delta = delta_q;
	assign last = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			len_q <= '0;
			idx_q <= '0;
			cnt_q <= '0;
			found_q <= 1'b0;
			strobe_q <= 1'b0;
			kind_q <= KIND_NOPROG;
			fired_q <= '0;
			delta_q <= '0;
			last_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						found_q <= 1'b0;
						if (op == OP_ADD && slot_ok && !active_q[slot_ix]) idx_q <= len_q;
						else idx_q <= '0;
						if (op == OP_ADD && slot_ok) active_q[slot_ix] <= 1'b1;
						else if (op == OP_CANCEL && slot_ok) active_q[slot_ix] <= 1'b0;
					end
				end
				ST_RM_RD: begin
					if (idx_end) begin
						len_q <= len_q - LW'(found_q);
						idx_q <= (op_q == OP_ADD) ? len_q - LW'(found_q) : '0;
					end
				end
				ST_RM_CHK: begin
					if (q_rd == slot_q) found_q <= 1'b1;
					idx_q <= idx_inc;
				end
				ST_INS_CHK: begin
					if (e_gt_exp) idx_q <= idx_dec;
				end
				ST_INS_WR: begin
					len_q <= len_q + LW'(1);
					idx_q <= '0;
				end
				ST_DRV_RD: begin
					if (idx_end) begin
						cnt_q <= idx_q;
						idx_q <= '0;
					end
				end
				ST_DRV_CHK: begin
					if (!e_gt_now) begin
						active_q[cur_q] <= 1'b0;
						idx_q <= idx_inc;
					end else begin
						cnt_q <= idx_q;
						idx_q <= '0;
					end
				end
				ST_CMP_RD: begin
					if (cmp_done) begin
						len_q <= len_q - cnt_q;
						idx_q <= '0;
					end
				end
				ST_CMP_WR: idx_q <= idx_inc;
				ST_PRG_CHK: begin
					if (!emit_prog) idx_q <= idx_inc;
				end
				default: ;
			endcase

			strobe_q <= emit_fire | emit_prog | emit_none;
			if (emit_fire) begin
				kind_q <= KIND_FIRED;
				fired_q <= cur_w[3:0];
				delta_q <= '0;
				last_q <= 1'b0;
			end else if (emit_prog) begin
				kind_q <= KIND_PROG;
				fired_q <= '0;
				delta_q <= dclamp;
				last_q <= 1'b1;
			end else if (emit_none) begin
				kind_q <= KIND_NOPROG;
				fired_q <= '0;
				delta_q <= '0;
				last_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= op;
			slot_q <= slot_ix;
			exp_q <= expires;
			now_q <= now;
		end
		if (state_q == ST_INS_EXP || state_q == ST_DRV_EXP || state_q == ST_PRG_EXP)
			cur_q <= q_rd;
	end

`ifndef SYNTHESIS
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LW'(SLOTS))
		else $error("queue length above slot count");
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(state_q) != ST_IDLE)
		else $error("result without a transaction in flight");
	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (kind == KIND_FIRED || kind == KIND_PROG || kind == KIND_NOPROG))
		else $error("illegal result kind");
	a_fired_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && kind == KIND_FIRED) |-> !last)
		else $error("fired result marked last");
	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && last) |=> !strobe)
		else $error("result right after the final one");
`endif
endmodule
